### hdl/fcsg_pkg.sv
// ----------------------------------------------------------------------------
// fcsg_pkg
// Types and constants shared by the filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

    localparam int COORD_W  = 16;
    localparam int COLOR_W  = 32;
    localparam int RAD_W    = 5;
    localparam int STEP_W   = RAD_W + 1;
    localparam int DEC_W    = 11;
    localparam int CNT_W    = 6;
    localparam logic [CNT_W-1:0] SPAN_MAX = 6'd63;

    typedef enum logic [2:0] {
        PH_CY_HI,
        PH_CY_LO,
        PH_CX_LO,
        PH_CX_HI,
        PH_CENTER,
        PH_NONE
    } phase_t;

    // First span of an iteration, given whether cy moved in the last step.
    function automatic phase_t first_phase(input logic cy_chg,
                                           input logic [STEP_W-1:0] cx,
                                           input logic [STEP_W-1:0] cy);
        phase_t ph;
        if (cy_chg && (cy != '0))
            ph = PH_CY_HI;
        else if (cx != cy)
            ph = (cx == '0) ? PH_CENTER : PH_CX_LO;
        else
            ph = PH_NONE;
        return ph;
    endfunction

endpackage

### hdl/filled_circle_span_generator.sv
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Midpoint filled circle rasterizer emitting one horizontal span per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one circle request: center,
//   radius and color. in_ready is high only while no circle is in progress.
//   Output channel (span_valid/span_ready) delivers the spans of the filled
//   circle, one per beat, span_last set on the final one.
//   A single sequencer walks the midpoint recurrence; each cycle, unless stalled,
//   it either produces one span or, on iterations with nothing to draw, only steps.
//   One held-back span stage lets span_last be known before a span is shown.
//   Radius 31 gives 63 spans. A zero radius is accepted and produces
//   nothing; in_ready stays high.
//   When the receiver stalls, generation holds once the output register and
//   the held-back stage are both full; nothing is lost.
//   Reset clears the sequencer and both valid flags; no circle in progress.
// ----------------------------------------------------------------------------
module filled_circle_span_generator #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   center_x,
    input  logic signed [15:0]   center_y,
    input  logic        [4:0]    radius,
    input  logic        [31:0]   color_rgba,
    output logic                 span_valid,
    input  logic                 span_ready,
    output logic signed [15:0]   span_row,
    output logic signed [15:0]   span_left,
    output logic signed [15:0]   span_right,
    output logic        [31:0]   span_color,
    output logic                 span_last
);
    import fcsg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH
    } state_t;

    state_t                   state_reg;
    phase_t                   phase_reg;
    logic [STEP_W-1:0]        cx_reg;
    logic [STEP_W-1:0]        cy_reg;
    logic signed [DEC_W-1:0]  df_reg;
    logic signed [DEC_W-1:0]  de_reg;
    logic signed [DEC_W-1:0]  dse_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [COORD_W-1:0]       ctr_x_reg;
    logic [COORD_W-1:0]       ctr_y_reg;
    logic [COLOR_W-1:0]       color_reg;

    logic                     pend_valid_reg;
    logic [COORD_W-1:0]       pend_row_reg;
    logic [COORD_W-1:0]       pend_left_reg;
    logic [COORD_W-1:0]       pend_right_reg;

    logic                     span_valid_reg;
    logic [COORD_W-1:0]       span_row_reg;
    logic [COORD_W-1:0]       span_left_reg;
    logic [COORD_W-1:0]       span_right_reg;
    logic [COLOR_W-1:0]       span_color_reg;
    logic                     span_last_reg;

    logic [RAD_W-1:0]         rad_sat;
    logic [STEP_W-1:0]        rad_ext;
    logic [STEP_W-1:0]        row_off;
    logic                     row_neg;
    logic [STEP_W-1:0]        half_w;
    logic [COORD_W-1:0]       cand_row;
    logic [COORD_W-1:0]       cand_left;
    logic [COORD_W-1:0]       cand_right;
    logic                     emit;
    logic                     keep;
    logic                     out_free;
    logic                     stall;
    logic                     out_load;
    logic                     iter_end;
    phase_t                   phase_in_iter;
    logic                     step_se;
    logic [STEP_W-1:0]        cx_next;
    logic [STEP_W-1:0]        cy_next;
    logic signed [DEC_W-1:0]  df_next;
    logic signed [DEC_W-1:0]  de_next;
    logic signed [DEC_W-1:0]  dse_next;

    assign rad_sat = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
    assign rad_ext = {1'b0, rad_sat};

    always_comb
    begin
        row_off       = '0;
        row_neg       = 1'b0;
        half_w        = cy_reg;
        iter_end      = 1'b1;
        phase_in_iter = PH_NONE;
        case (phase_reg)
            PH_CY_HI:
            begin
                row_off       = cy_reg;
                half_w        = cx_reg;
                iter_end      = 1'b0;
                phase_in_iter = PH_CY_LO;
            end
            PH_CY_LO:
            begin
                row_off       = cy_reg;
                row_neg       = 1'b1;
                half_w        = cx_reg;
                iter_end      = (cx_reg == cy_reg);
                phase_in_iter = (cx_reg == '0) ? PH_CENTER : PH_CX_LO;
            end
            PH_CX_LO:
            begin
                row_off       = cx_reg;
                row_neg       = 1'b1;
                iter_end      = 1'b0;
                phase_in_iter = PH_CX_HI;
            end
            PH_CX_HI:
            begin
                row_off = cx_reg;
            end
            PH_CENTER:
            begin
                row_off = '0;
            end
            default:
            begin
                row_off = '0;
            end
        endcase

        cand_row   = row_neg ? ctr_y_reg - COORD_W'(row_off)
                             : ctr_y_reg + COORD_W'(row_off);
        cand_left  = ctr_x_reg - COORD_W'(half_w);
        cand_right = ctr_x_reg + COORD_W'(half_w);

        emit     = (state_reg == S_RUN) && (phase_reg != PH_NONE);
        keep     = emit && (count_reg != SPAN_MAX);
        out_free = !span_valid_reg || span_ready;
        stall    = keep && pend_valid_reg && !out_free;
        out_load = ((state_reg == S_RUN) && !stall && keep && pend_valid_reg)
                || ((state_reg == S_FLUSH) && pend_valid_reg && out_free);

        step_se  = !df_reg[DEC_W-1];
        cx_next  = cx_reg + STEP_W'(1);
        cy_next  = step_se ? cy_reg - STEP_W'(1) : cy_reg;
        df_next  = df_reg + (step_se ? dse_reg : de_reg);
        de_next  = de_reg + DEC_W'(2);
        dse_next = dse_reg + (step_se ? DEC_W'(4) : DEC_W'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_NONE;
            cx_reg         <= '0;
            cy_reg         <= '0;
            df_reg         <= '0;
            de_reg         <= '0;
            dse_reg        <= '0;
            count_reg      <= '0;
            ctr_x_reg      <= '0;
            ctr_y_reg      <= '0;
            color_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_row_reg   <= '0;
            pend_left_reg  <= '0;
            pend_right_reg <= '0;
            span_valid_reg <= 1'b0;
            span_row_reg   <= '0;
            span_left_reg  <= '0;
            span_right_reg <= '0;
            span_color_reg <= '0;
            span_last_reg  <= 1'b0;
        end
        else
        begin
            if (span_valid_reg && span_ready && !out_load)
                span_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && (rad_sat != '0))
                    begin
                        ctr_x_reg <= center_x;
                        ctr_y_reg <= center_y;
                        color_reg <= color_rgba;
                        cx_reg    <= '0;
                        cy_reg    <= rad_ext;
                        df_reg    <= DEC_W'(1) - DEC_W'(rad_ext);
                        de_reg    <= DEC_W'(3);
                        dse_reg   <= DEC_W'(5) - DEC_W'({rad_ext, 1'b0});
                        count_reg <= '0;
                        phase_reg <= first_phase(1'b1, '0, rad_ext);
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (!stall)
                    begin
                        if (keep)
                        begin
                            if (pend_valid_reg)
                            begin
                                span_valid_reg <= 1'b1;
                                span_row_reg   <= pend_row_reg;
                                span_left_reg  <= pend_left_reg;
                                span_right_reg <= pend_right_reg;
                                span_color_reg <= color_reg;
                                span_last_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_row_reg   <= cand_row;
                            pend_left_reg  <= cand_left;
                            pend_right_reg <= cand_right;
                            count_reg      <= count_reg + CNT_W'(1);
                        end
                        if (iter_end)
                        begin
                            cx_reg  <= cx_next;
                            cy_reg  <= cy_next;
                            df_reg  <= df_next;
                            de_reg  <= de_next;
                            dse_reg <= dse_next;
                            if (cx_next > cy_next)
                                state_reg <= S_FLUSH;
                            else
                                phase_reg <= first_phase(step_se, cx_next, cy_next);
                        end
                        else
                        begin
                            phase_reg <= phase_in_iter;
                        end
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        span_valid_reg <= 1'b1;
                        span_row_reg   <= pend_row_reg;
                        span_left_reg  <= pend_left_reg;
                        span_right_reg <= pend_right_reg;
                        span_color_reg <= color_reg;
                        span_last_reg  <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign span_valid = span_valid_reg;
    assign span_row   = span_row_reg;
    assign span_left  = span_left_reg;
    assign span_right = span_right_reg;
    assign span_color = span_color_reg;
    assign span_last  = span_last_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Span-level check of the filled circle span generator.
// Circle requests go in through a valid/ready channel and the emitted spans
// are compared field by field, in order, against spans listed by hand or computed
// here with the midpoint recurrence. A short table of directed circles comes first, then
// random circles, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import fcsg_pkg::*;

    localparam int MAX_RAD    = 31;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM   = 88;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] left;
        logic [15:0] right;
        logic [31:0] color;
        logic        last;
    } span_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [4:0]  r;
        logic [31:0] color;
        logic        typed;
        int          first;
        int          cnt;
    } circle_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] center_x = '0;
    logic signed [15:0] center_y = '0;
    logic [4:0] radius = '0;
    logic [31:0] color_rgba = '0;
    logic span_valid;
    logic span_ready = 1'b0;
    logic signed [15:0] span_row;
    logic signed [15:0] span_left;
    logic signed [15:0] span_right;
    logic [31:0] span_color;
    logic span_last;

    span_t       span_q[$];
    span_t       circle_spans[$];
    span_t       typed_spans[$];
    circle_row_t circle_table[$];
    int          typed_cursor = 0;
    int          n_errors = 0;
    int          stall_left = 0;
    int          rx_cycles = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    filled_circle_span_generator #(.MAX_RADIUS(MAX_RAD)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .color_rgba (color_rgba),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span_row   (span_row),
        .span_left  (span_left),
        .span_right (span_right),
        .span_color (span_color),
        .span_last  (span_last)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 16)
            return $urandom_range(1, 3);
        else if (sel < 19)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void stage_span(input logic [15:0] row, input logic [15:0] left,
                                       input logic [15:0] right, input logic [31:0] color);
        span_t s;
        if (circle_spans.size() >= int'(SPAN_MAX))
            return;
        s.row   = row;
        s.left  = left;
        s.right = right;
        s.color = color;
        s.last  = 1'b0;
        circle_spans.push_back(s);
    endfunction

    // Midpoint walk; spans of one circle are staged, then the last one flagged.
    function automatic void predict_circle_spans(input logic [15:0] ox, input logic [15:0] oy,
                                                 input logic [4:0] r, input logic [31:0] color);
        int cx;
        int cy;
        int prev_cx;
        int prev_cy;
        int df;
        int d_e;
        int d_se;
        int rad;
        logic [15:0] ucx;
        logic [15:0] ucy;
        span_t s;
        circle_spans.delete();
        rad = int'(r);
        if (rad > MAX_RAD)
            rad = MAX_RAD;
        if (rad == 0)
            return;
        cx = 0;
        cy = rad;
        prev_cx = -1;
        prev_cy = -1;
        df = 1 - rad;
        d_e = 3;
        d_se = 5 - 2 * rad;
        do
        begin
            ucx = 16'(cx);
            ucy = 16'(cy);
            if (prev_cy != cy)
            begin
                if (cy > 0)
                begin
                    stage_span(oy + ucy, ox - ucx, ox + ucx, color);
                    stage_span(oy - ucy, ox - ucx, ox + ucx, color);
                end
                prev_cy = cy;
            end
            if (prev_cx != cx)
            begin
                if (cx != cy)
                begin
                    if (cx > 0)
                    begin
                        stage_span(oy - ucx, ox - ucy, ox + ucy, color);
                        stage_span(oy + ucx, ox - ucy, ox + ucy, color);
                    end
                    else
                        stage_span(oy, ox - ucy, ox + ucy, color);
                end
                prev_cx = cx;
            end
            if (df < 0)
            begin
                df += d_e;
                d_e += 2;
                d_se += 2;
            end
            else
            begin
                df += d_se;
                d_e += 2;
                d_se += 4;
                cy--;
            end
            cx++;
        end
        while (cx <= cy);
        foreach (circle_spans[i])
        begin
            s = circle_spans[i];
            s.last = (i == circle_spans.size() - 1);
            span_q.push_back(s);
        end
    endfunction

    function automatic void add_typed(input logic [15:0] row, input logic [15:0] left,
                                      input logic [15:0] right, input logic [31:0] color,
                                      input logic last);
        span_t s;
        s.row   = row;
        s.left  = left;
        s.right = right;
        s.color = color;
        s.last  = last;
        typed_spans.push_back(s);
    endfunction

    function automatic void add_circle(input logic [15:0] x, input logic [15:0] y,
                                       input logic [4:0] r, input logic [31:0] color,
                                       input logic typed, input int cnt);
        circle_row_t c;
        c.x     = x;
        c.y     = y;
        c.r     = r;
        c.color = color;
        c.typed = typed;
        c.first = typed_cursor;
        c.cnt   = cnt;
        typed_cursor += cnt;
        circle_table.push_back(c);
    endfunction

    task automatic send_circle(input logic [15:0] x, input logic [15:0] y, input logic [4:0] r,
                               input logic [31:0] color, input logic typed,
                               input int first, input int cnt);
        int gap;
        gap = (!tx_calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        center_x   <= x;
        center_y   <= y;
        radius     <= r;
        color_rgba <= color;
        do
            @(posedge clk);
        while (!in_ready);
        if (typed)
        begin
            for (int i = first; i < first + cnt; i++)
                span_q.push_back(typed_spans[i]);
        end
        else
            predict_circle_spans(x, y, r, color);
    endtask

    task automatic drain_spans();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (span_q.size() != 0);
    endtask

    // Receiver: random stalls, with calm stretches.
    always @(posedge clk)
    begin
        rx_cycles++;
        if (rx_cycles % 300 == 0)
            rx_calm = ($urandom_range(0, 2) == 0);
        if (stall_left > 0)
        begin
            stall_left--;
            span_ready <= 1'b0;
        end
        else if (!rx_calm && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap() - 1;
            span_ready <= 1'b0;
        end
        else
            span_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        span_t want;
        if (rst_n && span_valid && span_ready)
        begin
            if (span_q.size() == 0)
                report_mismatch($sformatf("unexpected span row %0d", span_row));
            else
            begin
                want = span_q.pop_front();
                if (span_row !== want.row)
                    report_mismatch($sformatf("span_row %0d, want %0d",
                                              span_row, $signed(want.row)));
                if (span_left !== want.left)
                    report_mismatch($sformatf("span_left %0d, want %0d (row %0d)",
                                              span_left, $signed(want.left), $signed(want.row)));
                if (span_right !== want.right)
                    report_mismatch($sformatf("span_right %0d, want %0d (row %0d)",
                                              span_right, $signed(want.right), $signed(want.row)));
                if (span_color !== want.color)
                    report_mismatch($sformatf("span_color %h, want %h", span_color, want.color));
                if (span_last !== want.last)
                    report_mismatch($sformatf("span_last %b, want %b (row %0d)",
                                              span_last, want.last, $signed(want.row)));
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (span_valid && span_ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        circle_row_t c;
        int n_sent;
        logic [15:0] x;
        logic [15:0] y;
        logic [4:0] r;

        // zero radius: nothing
        add_circle(16'sd0, 16'sd0, 5'd0, 32'h0000_0000, 1'b1, 0);
        add_circle(16'h7fff, 16'h8000, 5'd0, 32'hffff_ffff, 1'b1, 0);
        // radius 1: two single-pixel rows, then the centre row
        add_typed(16'd1, 16'd0, 16'd0, 32'h1234_5678, 1'b0);
        add_typed(16'hffff, 16'd0, 16'd0, 32'h1234_5678, 1'b0);
        add_typed(16'd0, 16'hffff, 16'd1, 32'h1234_5678, 1'b1);
        add_circle(16'sd0, 16'sd0, 5'd1, 32'h1234_5678, 1'b1, 3);
        // radius 1 at the corner, everything wraps
        add_typed(16'h8001, 16'h7fff, 16'h7fff, 32'hffff_ffff, 1'b0);
        add_typed(16'h7fff, 16'h7fff, 16'h7fff, 32'hffff_ffff, 1'b0);
        add_typed(16'h8000, 16'h7ffe, 16'h8000, 32'hffff_ffff, 1'b1);
        add_circle(16'h7fff, 16'h8000, 5'd1, 32'hffff_ffff, 1'b1, 3);
        add_circle(16'h8000, 16'h7fff, 5'd1, 32'h0000_0000, 1'b0, 0);
        add_circle(16'sd0, 16'sd0, 5'd2, 32'h8000_0001, 1'b0, 0);
        add_circle(16'sd10, -16'sd10, 5'd3, 32'h0102_0304, 1'b0, 0);
        add_circle(-16'sd1, -16'sd1, 5'd4, 32'hdead_beef, 1'b0, 0);
        add_circle(16'sd100, -16'sd100, 5'd5, 32'h5a5a_5a5a, 1'b0, 0);
        add_circle(16'sd0, 16'sd0, 5'd31, 32'ha5a5_a5a5, 1'b0, 0);
        add_circle(16'h7fff, 16'h7fff, 5'd31, 32'hffff_ffff, 1'b0, 0);
        add_circle(16'h8000, 16'h8000, 5'd31, 32'h0000_0000, 1'b0, 0);
        add_circle(-16'sd1, 16'sd1, 5'd31, 32'h7f7f_7f7f, 1'b0, 0);
        add_circle(16'h7ff0, 16'h8008, 5'd30, 32'hff00_ff00, 1'b0, 0);
        add_circle(16'sd1234, -16'sd4321, 5'd16, 32'h00ff_00ff, 1'b0, 0);
        add_circle(-16'sd300, 16'sd300, 5'd15, 32'hcafe_f00d, 1'b0, 0);
        add_circle(16'sd7, 16'sd8, 5'd8, 32'h0f0f_0f0f, 1'b0, 0);
        add_circle(16'sd8, 16'sd7, 5'd7, 32'hf0f0_f0f0, 1'b0, 0);
        add_circle(16'h8000, 16'h7fff, 5'd0, 32'h1111_1111, 1'b0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (circle_table[i])
        begin
            c = circle_table[i];
            send_circle(c.x, c.y, c.r, c.color, c.typed, c.first, c.cnt);
        end
        drain_spans();

        n_sent = 0;
        while (n_sent < N_RANDOM)
        begin
            if (n_sent % 16 == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                x = 16'h7ff0 + 16'($urandom_range(0, 31));
                y = 16'h7ff0 + 16'($urandom_range(0, 31));
            end
            else
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            case ($urandom_range(0, 9))
                0: r = 5'd0;
                1, 2: r = 5'($urandom_range(25, 31));
                default: r = 5'($urandom_range(1, 31));
            endcase
            send_circle(x, y, r, $urandom, 1'b0, 0, 0);
            if (r != 5'd0)
                n_sent++;
            if (n_sent == N_RANDOM / 2 && r != 5'd0)
                drain_spans();
        end
        in_valid <= 1'b0;

        while (span_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0 && span_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
